### design/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// action codes, word classes, angle limits and the arctangent table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_SUB   = 2'd1,
        ACT_MAG   = 2'd2,
        ACT_ANGLE = 2'd3
    } t_action;

    // how the back part treats a word
    typedef enum logic [1:0] {
        KIND_ARITH  = 2'd0,
        KIND_MAG    = 2'd1,
        KIND_CORDIC = 2'd2,
        KIND_FIXED  = 2'd3
    } t_kind;

    localparam int KIND_WIDTH  = 2;
    localparam int ANGLE_WIDTH = 15;
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_LIMIT = 15'sd12868;

    // operands are scaled so that their top bit sits at bit X_SCALE - 1
    localparam int X_SCALE    = 40;
    localparam int X_WIDTH    = 43;
    localparam int Z_WIDTH    = 33;
    localparam int ATAN_WIDTH = 31;
    localparam int ROUND_SHIFT = 17;

    // atan(2^-i) * 2^30, truncated
    function automatic logic [ATAN_WIDTH-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_WIDTH-1:0] v;
        unique case (idx)
            5'd0:  v = 31'd843314856;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043836;
            5'd3:  v = 31'd133525158;
            5'd4:  v = 31'd67021686;
            5'd5:  v = 31'd33543515;
            5'd6:  v = 31'd16775850;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194282;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048575;
            5'd11: v = 31'd524287;
            5'd12: v = 31'd262143;
            5'd13: v = 31'd131071;
            5'd14: v = 31'd65535;
            5'd15: v = 31'd32767;
            5'd16: v = 31'd16383;
            5'd17: v = 31'd8191;
            5'd18: v = 31'd4095;
            5'd19: v = 31'd2047;
            5'd20: v = 31'd1023;
            5'd21: v = 31'd511;
            5'd22: v = 31'd255;
            5'd23: v = 31'd127;
            5'd24: v = 31'd63;
            5'd25: v = 31'd31;
            5'd26: v = 31'd15;
            5'd27: v = 31'd7;
            5'd28: v = 31'd3;
            5'd29: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/complex_arith_unit.sv
// ---------------------------------------------------------------------------
// complex_arith_unit: complex add, subtract, magnitude and angle
// front classifies, two-word queue, back runs square root and cordic stages
// ---------------------------------------------------------------------------
// path: an accepted input word passes the queue, the input register, one register
//   per back stage and the output register
// throughput: one word per cycle unless stalled, set by the fully pipelined back stages
// reset: synchronous active low, clears queue pointers and count and the valid bits only
`timescale 1ns / 1ps
`default_nettype none

module complex_arith_unit #(
    parameter int PART_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [1:0]                        i_action,
    input  wire logic signed [PART_WIDTH-1:0]      i_a_real,
    input  wire logic signed [PART_WIDTH-1:0]      i_a_imag,
    input  wire logic signed [PART_WIDTH-1:0]      i_b_real,
    input  wire logic signed [PART_WIDTH-1:0]      i_b_imag,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [PART_WIDTH:0]             o_out_real,
    output logic signed [PART_WIDTH:0]             o_out_imag,
    output logic [PART_WIDTH-1:0]                  o_out_magnitude,
    output logic signed [cau_pkg::ANGLE_WIDTH-1:0] o_out_angle,
    output logic                                   o_undefined
);

    localparam int SW = 2 * PART_WIDTH;
    localparam int XW = cau_pkg::X_WIDTH;
    localparam int AW = cau_pkg::ANGLE_WIDTH;
    localparam int KW = cau_pkg::KIND_WIDTH;
    // queue word: kind, sums, squares, scaled operand, fixed angle, flag
    localparam int QW = KW + 2 * (PART_WIDTH + 1) + 2 * SW + 2 * XW + AW + 1;

    // front outputs
    cau_pkg::t_kind             f_kind;
    logic signed [PART_WIDTH:0] f_rr, f_ri;
    logic [SW-1:0]              f_sq_re, f_sq_im;
    logic signed [XW-1:0]       f_x0, f_y0;
    logic signed [AW-1:0]       f_fix;
    logic                       f_undef;

    // queue side
    logic [QW-1:0]              q_in, q_out;
    logic                       q_full, q_valid, q_pop;

    cau_pkg::t_kind             b_kind;
    logic signed [PART_WIDTH:0] b_rr, b_ri;
    logic [SW-1:0]              b_sq_re, b_sq_im;
    logic signed [XW-1:0]       b_x0, b_y0;
    logic signed [AW-1:0]       b_fix;
    logic                       b_undef;

    cau_front #(
        .PART_WIDTH (PART_WIDTH)
    ) u_front (
        .i_action    (i_action),
        .i_a_real    (i_a_real),
        .i_a_imag    (i_a_imag),
        .i_b_real    (i_b_real),
        .i_b_imag    (i_b_imag),
        .o_kind      (f_kind),
        .o_rr        (f_rr),
        .o_ri        (f_ri),
        .o_sq_re     (f_sq_re),
        .o_sq_im     (f_sq_im),
        .o_x0        (f_x0),
        .o_y0        (f_y0),
        .o_fix_angle (f_fix),
        .o_undef     (f_undef)
    );

    assign q_in = {f_kind, f_rr, f_ri, f_sq_re, f_sq_im, f_x0, f_y0, f_fix, f_undef};

    // input word held off only while both queue entries are taken
    assign o_stall = q_full;

    cau_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    always_comb begin
        b_kind  = cau_pkg::t_kind'(q_out[QW-1 -: KW]);
        {b_rr, b_ri, b_sq_re, b_sq_im, b_x0, b_y0, b_fix, b_undef} = q_out[QW-KW-1:0];
    end

    cau_back #(
        .PART_WIDTH   (PART_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_kind      (b_kind),
        .i_rr        (b_rr),
        .i_ri        (b_ri),
        .i_sq_re     (b_sq_re),
        .i_sq_im     (b_sq_im),
        .i_x0        (b_x0),
        .i_y0        (b_y0),
        .i_fix_angle (b_fix),
        .i_undef     (b_undef),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_real      (o_out_real),
        .o_imag      (o_out_imag),
        .o_magnitude (o_out_magnitude),
        .o_angle     (o_out_angle),
        .o_undefined (o_undefined)
    );

    // undefined angle carries a zero angle and nothing else
    a_undef_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_undefined |-> o_out_angle == '0 && o_out_magnitude == '0)
        else $error("undefined flag with non-zero result");

    // arithmetic results exclude magnitude and angle
    a_arith_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_real != '0 || o_out_imag != '0)
            |-> o_out_magnitude == '0 && o_out_angle == '0 && !o_undefined)
        else $error("mixed result word");

    // angle stays within plus or minus pi over two
    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_angle <= cau_pkg::ANGLE_LIMIT
                 && o_out_angle >= -cau_pkg::ANGLE_LIMIT)
        else $error("angle out of range");

endmodule

`default_nettype wire

### design/cau_front.sv
// ---------------------------------------------------------------------------
// cau_front: front part of the complex arithmetic unit
// classifies a word, does add and subtract, squares and scales the operand
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cau_front #(
    parameter int PART_WIDTH = 16
) (
    input  wire logic [1:0]                          i_action,
    input  wire logic signed [PART_WIDTH-1:0]        i_a_real,
    input  wire logic signed [PART_WIDTH-1:0]        i_a_imag,
    input  wire logic signed [PART_WIDTH-1:0]        i_b_real,
    input  wire logic signed [PART_WIDTH-1:0]        i_b_imag,
    output cau_pkg::t_kind                           o_kind,
    output logic signed [PART_WIDTH:0]               o_rr,
    output logic signed [PART_WIDTH:0]               o_ri,
    output logic [2*PART_WIDTH-1:0]                  o_sq_re,
    output logic [2*PART_WIDTH-1:0]                  o_sq_im,
    output logic signed [cau_pkg::X_WIDTH-1:0]       o_x0,
    output logic signed [cau_pkg::X_WIDTH-1:0]       o_y0,
    output logic signed [cau_pkg::ANGLE_WIDTH-1:0]   o_fix_angle,
    output logic                                     o_undef
);

    localparam int FRAC = cau_pkg::X_SCALE - PART_WIDTH;

    cau_pkg::t_action           act;
    logic signed [PART_WIDTH:0] ar_e, ai_e, br_e, bi_e;
    logic signed [PART_WIDTH:0] abs_r, abs_i, cr, ci;
    logic [PART_WIDTH-1:0]      ur, ui;
    logic                       re_zero, im_zero;

    always_comb begin
        act   = cau_pkg::t_action'(i_action);
        ar_e  = (PART_WIDTH+1)'(i_a_real);
        ai_e  = (PART_WIDTH+1)'(i_a_imag);
        br_e  = (PART_WIDTH+1)'(i_b_real);
        bi_e  = (PART_WIDTH+1)'(i_b_imag);
        abs_r = ar_e[PART_WIDTH] ? -ar_e : ar_e;
        abs_i = ai_e[PART_WIDTH] ? -ai_e : ai_e;
        ur    = abs_r[PART_WIDTH-1:0];
        ui    = abs_i[PART_WIDTH-1:0];
        // left half plane folds onto the right, the quotient keeps its value
        cr    = ar_e[PART_WIDTH] ? -ar_e : ar_e;
        ci    = ar_e[PART_WIDTH] ? -ai_e : ai_e;
        re_zero = (i_a_real == '0);
        im_zero = (i_a_imag == '0);

        o_sq_re = (2*PART_WIDTH)'(ur) * (2*PART_WIDTH)'(ur);
        o_sq_im = (2*PART_WIDTH)'(ui) * (2*PART_WIDTH)'(ui);
        o_x0    = cau_pkg::X_WIDTH'(cr) <<< FRAC;
        o_y0    = cau_pkg::X_WIDTH'(ci) <<< FRAC;

        o_rr        = '0;
        o_ri        = '0;
        o_fix_angle = '0;
        o_undef     = 1'b0;
        unique case (act)
            cau_pkg::ACT_ADD: begin
                o_kind = cau_pkg::KIND_ARITH;
                o_rr   = ar_e + br_e;
                o_ri   = ai_e + bi_e;
            end
            cau_pkg::ACT_SUB: begin
                o_kind = cau_pkg::KIND_ARITH;
                o_rr   = ar_e - br_e;
                o_ri   = ai_e - bi_e;
            end
            cau_pkg::ACT_MAG: begin
                o_kind = cau_pkg::KIND_MAG;
            end
            default: begin
                priority if (re_zero && im_zero) begin
                    o_kind  = cau_pkg::KIND_FIXED;
                    o_undef = 1'b1;
                end else if (re_zero) begin
                    o_kind      = cau_pkg::KIND_FIXED;
                    o_fix_angle = i_a_imag[PART_WIDTH-1] ? -cau_pkg::ANGLE_LIMIT
                                                         : cau_pkg::ANGLE_LIMIT;
                end else if (im_zero) begin
                    o_kind = cau_pkg::KIND_FIXED;
                end else begin
                    o_kind = cau_pkg::KIND_CORDIC;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### design/cau_queue.sv
// ---------------------------------------------------------------------------
// cau_queue: two-entry queue between front and back
// decouples the input handshake from the back pipeline stall
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cau_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_mem [0:1];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### design/cau_back.sv
// ---------------------------------------------------------------------------
// cau_back: back pipeline of the complex arithmetic unit
// up to one square root digit and one cordic rotation per stage, then rounding
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cau_back #(
    parameter int PART_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_q_valid,
    output logic                                      o_q_pop,
    input  wire cau_pkg::t_kind                       i_kind,
    input  wire logic signed [PART_WIDTH:0]           i_rr,
    input  wire logic signed [PART_WIDTH:0]           i_ri,
    input  wire logic [2*PART_WIDTH-1:0]              i_sq_re,
    input  wire logic [2*PART_WIDTH-1:0]              i_sq_im,
    input  wire logic signed [cau_pkg::X_WIDTH-1:0]   i_x0,
    input  wire logic signed [cau_pkg::X_WIDTH-1:0]   i_y0,
    input  wire logic signed [cau_pkg::ANGLE_WIDTH-1:0] i_fix_angle,
    input  wire logic                                 i_undef,
    input  wire logic                                 i_stall,
    output logic                                      o_valid,
    output logic signed [PART_WIDTH:0]                o_real,
    output logic signed [PART_WIDTH:0]                o_imag,
    output logic [PART_WIDTH-1:0]                     o_magnitude,
    output logic signed [cau_pkg::ANGLE_WIDTH-1:0]    o_angle,
    output logic                                      o_undefined
);

    localparam int L  = (PART_WIDTH > CORDIC_STEPS) ? PART_WIDTH : CORDIC_STEPS;
    localparam int SW = 2 * PART_WIDTH;
    localparam int XW = cau_pkg::X_WIDTH;
    localparam int ZW = cau_pkg::Z_WIDTH;
    localparam int AW = cau_pkg::ANGLE_WIDTH;
    localparam int QW = ZW - cau_pkg::ROUND_SHIFT;

    logic                 advance;
    logic                 r_v     [0:L];
    cau_pkg::t_kind       r_kind  [0:L];
    logic signed [PART_WIDTH:0] r_rr [0:L];
    logic signed [PART_WIDTH:0] r_ri [0:L];
    logic [SW-1:0]        r_rem   [0:L];
    logic [SW-1:0]        r_root  [0:L];
    logic signed [XW-1:0] r_x     [0:L];
    logic signed [XW-1:0] r_y     [0:L];
    logic signed [ZW-1:0] r_z     [0:L];
    logic signed [AW-1:0] r_fix   [0:L];
    logic                 r_undef [0:L];

    // whole pipeline moves unless the output word is held
    assign advance = !o_valid || !i_stall;
    assign o_q_pop = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (advance) begin
            r_v[0] <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind[0]  <= i_kind;
            r_rr[0]    <= i_rr;
            r_ri[0]    <= i_ri;
            r_rem[0]   <= i_sq_re + i_sq_im;
            r_root[0]  <= '0;
            r_x[0]     <= i_x0;
            r_y[0]     <= i_y0;
            r_z[0]     <= '0;
            r_fix[0]   <= i_fix_angle;
            r_undef[0] <= i_undef;
        end
    end

    for (genvar k = 0; k < L; k++) begin : g_stage
        localparam int SHIFT = (k < PART_WIDTH) ? 2 * (PART_WIDTH - 1 - k) : 0;
        localparam logic [SW-1:0] BIT = SW'(1) << SHIFT;

        logic [SW-1:0]        n_rem, n_root, trial;
        logic signed [XW-1:0] n_x, n_y;
        logic signed [ZW-1:0] n_z, ang;

        always_comb begin
            trial  = r_root[k] + BIT;
            n_rem  = r_rem[k];
            n_root = r_root[k];
            if (k < PART_WIDTH) begin
                if (r_rem[k] >= trial) begin
                    n_rem  = r_rem[k] - trial;
                    n_root = (r_root[k] >> 1) + BIT;
                end else begin
                    n_root = r_root[k] >> 1;
                end
            end
            ang = $signed(ZW'(cau_pkg::atan_entry(5'(k))));
            n_x = r_x[k];
            n_y = r_y[k];
            n_z = r_z[k];
            if (k < CORDIC_STEPS) begin
                if (!r_y[k][XW-1]) begin
                    n_x = r_x[k] + (r_y[k] >>> k);
                    n_y = r_y[k] - (r_x[k] >>> k);
                    n_z = r_z[k] + ang;
                end else begin
                    n_x = r_x[k] - (r_y[k] >>> k);
                    n_y = r_y[k] + (r_x[k] >>> k);
                    n_z = r_z[k] - ang;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (advance) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_kind[k+1]  <= r_kind[k];
                r_rr[k+1]    <= r_rr[k];
                r_ri[k+1]    <= r_ri[k];
                r_rem[k+1]   <= n_rem;
                r_root[k+1]  <= n_root;
                r_x[k+1]     <= n_x;
                r_y[k+1]     <= n_y;
                r_z[k+1]     <= n_z;
                r_fix[k+1]   <= r_fix[k];
                r_undef[k+1] <= r_undef[k];
            end
        end
    end

    // final rounding of root and angle
    logic [SW-1:0]        root_rnd;
    logic                 z_neg;
    logic [ZW-1:0]        z_abs, z_rnd;
    logic [QW-1:0]        q_abs;
    logic signed [AW-1:0] q_lim, n_angle;

    always_comb begin
        root_rnd = (r_rem[L] > r_root[L]) ? r_root[L] + SW'(1) : r_root[L];
        z_neg    = r_z[L][ZW-1];
        z_abs    = z_neg ? ZW'(-r_z[L]) : ZW'(r_z[L]);
        z_rnd    = (z_abs + (ZW'(1) << (cau_pkg::ROUND_SHIFT - 1))) >> cau_pkg::ROUND_SHIFT;
        q_abs    = z_rnd[QW-1:0];
        q_lim    = (q_abs > QW'(cau_pkg::ANGLE_LIMIT)) ? cau_pkg::ANGLE_LIMIT
                                                       : $signed(q_abs[AW-1:0]);
        unique case (r_kind[L])
            cau_pkg::KIND_CORDIC: n_angle = z_neg ? -q_lim : q_lim;
            cau_pkg::KIND_FIXED:  n_angle = r_fix[L];
            default:              n_angle = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (advance) begin
            o_valid <= r_v[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_real      <= (r_kind[L] == cau_pkg::KIND_ARITH) ? r_rr[L] : '0;
            o_imag      <= (r_kind[L] == cau_pkg::KIND_ARITH) ? r_ri[L] : '0;
            o_magnitude <= (r_kind[L] == cau_pkg::KIND_MAG) ? root_rnd[PART_WIDTH-1:0] : '0;
            o_angle     <= n_angle;
            o_undefined <= (r_kind[L] == cau_pkg::KIND_FIXED) && r_undef[L];
        end
    end

endmodule

`default_nettype wire
